// ===== hdl/rau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation and status codes, transfer payload structs and the request and
// response structs of the shared divider.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int WIDE_BITS = 2 * WORD_BITS;
    localparam int CNT_BITS  = $clog2(WIDE_BITS + 1);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               is_equal;
        logic [1:0]         status;
    } t_out_item;

    // Request to the shared divider: quotient and remainder of dividend/divisor
    typedef struct packed {
        logic                 start;
        logic [WIDE_BITS-1:0] dividend;
        logic [WIDE_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [WIDE_BITS-1:0] quot;
        logic [WIDE_BITS-1:0] rem;
    } t_div_rsp;

endpackage

// ===== hdl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: rational fraction arithmetic with gcd reduction
// Adds, subtracts, multiplies, divides or compares two signed fractions.
// ----------------------------------------------------------------------------
// Usage: present an operation on i_in_valid/i_in_data; it transfers when
// o_in_ready is high. The block then works on that one item alone and holds
// o_in_ready low until the result has been transferred on o_out_valid /
// o_out_data. Cross products are formed by 32x32 multipliers. Reduction
// runs Euclid's algorithm on one shared restoring divider, followed by two
// more divisions by the gcd. Compares, zero numerators and error cases skip
// the reduction. Euclid on 64-bit values takes at most about 93 steps,
// typical operands a handful.
// A held-off receiver simply keeps the result in the output register; nothing
// is lost.
// Synchronous active-low reset returns the sequencer to idle with no result
// pending; the other registers are not reset.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_COMB  = 4'd2;
    localparam logic [3:0] S_GCD   = 4'd3;
    localparam logic [3:0] S_GWAIT = 4'd4;
    localparam logic [3:0] S_DIVN  = 4'd5;
    localparam logic [3:0] S_WN    = 4'd6;
    localparam logic [3:0] S_WD    = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam logic [WIDE_BITS-1:0] HALF = WIDE_BITS'(1) << (WORD_BITS - 1);

    logic [3:0]           r_state, n_state;
    logic [2:0]           r_op;
    logic                 r_an_neg, r_bn_neg, r_neg;
    logic [WORD_BITS-1:0] r_an, r_ad, r_bn, r_bd;
    logic [WIDE_BITS-1:0] r_p0, r_p1, r_p2;
    logic [WIDE_BITS-1:0] r_n, r_d, r_x, r_y;
    t_out_item            r_out;
    t_div_req             w_req;
    t_div_rsp             w_rsp;

    function automatic logic [WORD_BITS-1:0] mag(input logic [31:0] v);
        logic [WORD_BITS-1:0] w;
        w = v[WORD_BITS-1:0];
        return w[WORD_BITS-1] ? (~w + 1'b1) : w;
    endfunction

    function automatic logic sgn(input logic [31:0] v);
        return v[WORD_BITS-1];
    endfunction

    logic [WIDE_BITS-1:0] w_t1, w_t2, w_sum, w_n;
    logic                 w_s1, w_s2, w_ssum;

    // signed-magnitude combine of the cross products
    always_comb begin
        w_t1 = r_p0;
        w_t2 = r_p1;
        w_s1 = r_an_neg;
        w_s2 = (r_op == OP_ADD) ? r_bn_neg : !r_bn_neg;
        if (w_s1 == w_s2) begin
            w_sum  = w_t1 + w_t2;
            w_ssum = w_s1;
        end else if (w_t1 >= w_t2) begin
            w_sum  = w_t1 - w_t2;
            w_ssum = w_s1;
        end else begin
            w_sum  = w_t2 - w_t1;
            w_ssum = w_s2;
        end
        if (w_sum == '0) w_ssum = 1'b0;
        w_n = (r_op == OP_MUL || r_op == OP_DIV) ? r_p0 : w_sum;
    end

    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_GCD: begin
                w_req.start    = 1'b1;
                w_req.dividend = r_x;
                w_req.divisor  = r_y;
            end
            S_DIVN: begin
                w_req.start    = 1'b1;
                w_req.dividend = r_n;
                w_req.divisor  = r_x;
            end
            S_WN: begin
                if (w_rsp.done) begin
                    w_req.start    = 1'b1;
                    w_req.dividend = r_d;
                    w_req.divisor  = r_x;
                end
            end
            default: ;
        endcase
    end

    rau_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_MUL;
            S_MUL: begin
                if (r_op > OP_CMP || r_ad == '0 || r_bd == '0
                    || (r_op == OP_DIV && r_bn == '0)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_COMB;
                end
            end
            S_COMB: begin
                if (r_op == OP_CMP || w_n == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD:   n_state = S_GWAIT;
            S_GWAIT: begin
                if (w_rsp.done) n_state = (w_rsp.rem == '0) ? S_DIVN : S_GCD;
            end
            S_DIVN:  n_state = S_WN;
            S_WN:    if (w_rsp.done) n_state = S_WD;
            S_WD:    if (w_rsp.done) n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_in_data.opcode;
                        r_an     <= mag(i_in_data.a_num);
                        r_ad     <= mag(i_in_data.a_den);
                        r_bn     <= mag(i_in_data.b_num);
                        r_bd     <= mag(i_in_data.b_den);
                        r_an_neg <= (sgn(i_in_data.a_num) != sgn(i_in_data.a_den))
                                    && (i_in_data.a_num[WORD_BITS-1:0] != '0);
                        r_bn_neg <= (sgn(i_in_data.b_num) != sgn(i_in_data.b_den))
                                    && (i_in_data.b_num[WORD_BITS-1:0] != '0);
                    end
                end
                S_MUL: begin
                    r_p0  <= (r_op == OP_MUL) ? WIDE_BITS'(r_an) * WIDE_BITS'(r_bn)
                                              : WIDE_BITS'(r_an) * WIDE_BITS'(r_bd);
                    r_p1  <= WIDE_BITS'(r_bn) * WIDE_BITS'(r_ad);
                    r_p2  <= (r_op == OP_DIV) ? WIDE_BITS'(r_ad) * WIDE_BITS'(r_bn)
                                              : WIDE_BITS'(r_ad) * WIDE_BITS'(r_bd);
                    if (r_op <= OP_CMP && (r_ad == '0 || r_bd == '0)) begin
                        r_out <= '{res_num: '0, res_den: '0, is_equal: 1'b0,
                                   status: ST_ZERO_DEN};
                    end else if (r_op == OP_DIV && r_bn == '0) begin
                        r_out <= '{res_num: '0, res_den: '0, is_equal: 1'b0,
                                   status: ST_DIV_ZERO};
                    end else begin
                        r_out <= '0;
                    end
                end
                S_COMB: begin
                    if (r_op == OP_MUL || r_op == OP_DIV) begin
                        r_n   <= r_p0;
                        r_neg <= r_an_neg != r_bn_neg;
                    end else begin
                        r_n   <= w_sum;
                        r_neg <= w_ssum;
                    end
                    r_d <= r_p2;
                    r_x <= w_n;
                    r_y <= r_p2;
                    if (r_op == OP_CMP) begin
                        r_out.is_equal <= (w_sum == '0);
                    end else if (w_n == '0) begin
                        r_out.res_den <= 31'd1;
                    end
                end
                S_GWAIT: begin
                    // Euclid: advance x, y <- y, x mod y until y is zero
                    if (w_rsp.done) begin
                        r_x <= r_y;
                        r_y <= w_rsp.rem;
                    end
                end
                S_WN: if (w_rsp.done) r_n <= w_rsp.quot;
                S_WD: if (w_rsp.done) r_d <= w_rsp.quot;
                S_FIN: begin
                    if (r_d > HALF - 1'b1 || r_n > (r_neg ? HALF : HALF - 1'b1)) begin
                        r_out.status <= ST_OVERFLOW;
                    end else begin
                        r_out.res_num <= 32'(r_neg ? (~r_n + 1'b1) : r_n);
                        r_out.res_den <= r_d[30:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

endmodule

// ===== hdl/rau_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_divider: shared restoring divider
// One quotient bit per cycle, WIDE_BITS bits in all; done pulses for one cycle.
// ----------------------------------------------------------------------------
module rau_divider import rau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [WIDE_BITS-1:0] r_quot, n_quot;
    logic [WIDE_BITS-1:0] r_rem, n_rem;
    logic [WIDE_BITS-1:0] r_dvsr, n_dvsr;
    logic [WIDE_BITS:0]   w_trial;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_dvsr  = r_dvsr;
        w_trial = {r_rem, r_quot[WIDE_BITS-1]} - {1'b0, r_dvsr};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_BITS'(WIDE_BITS);
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_dvsr = i_req.divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract when it fits
            if (!w_trial[WIDE_BITS]) begin
                n_rem  = w_trial[WIDE_BITS-1:0];
                n_quot = {r_quot[WIDE_BITS-2:0], 1'b1};
            end else begin
                n_rem  = {r_rem[WIDE_BITS-2:0], r_quot[WIDE_BITS-1]};
                n_quot = {r_quot[WIDE_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvsr <= n_dvsr;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule
